>>> rtl/core/stis_pkg.sv
// shared constants for the sorted table interval search block
package stis_pkg;

    localparam int KEY_WIDTH           = 32;
    localparam int INDEX_WIDTH         = 8;
    localparam int SIZE_WIDTH          = 9;
    localparam int DEFAULT_TABLE_DEPTH = 256;
    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int SIZE_RESET          = 256;

    localparam logic [SIZE_WIDTH-1:0] SIZE_MIN = SIZE_WIDTH'(2);

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

endpackage

>>> rtl/core/stis_req_if.sv
// request channel: table writes and key searches
interface stis_req_if #(
    parameter int VALUE_WIDTH = stis_pkg::DEFAULT_VALUE_WIDTH
);
    import stis_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [INDEX_WIDTH-1:0]        entry_index;
    logic signed [VALUE_WIDTH-1:0] entry_value;
    logic signed [KEY_WIDTH-1:0]   search_key;

    modport source (
        output valid, action, entry_index, entry_value, search_key,
        input  ready
    );

    modport sink (
        input  valid, action, entry_index, entry_value, search_key,
        output ready
    );
endinterface

>>> rtl/core/stis_rsp_if.sv
// response channel: search results
interface stis_rsp_if;
    import stis_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [INDEX_WIDTH-1:0] found_index;
    logic                   out_of_range;

    modport source (
        output valid, found_index, out_of_range,
        input  ready
    );

    modport sink (
        input  valid, found_index, out_of_range,
        output ready
    );
endinterface

>>> rtl/core/stis_cfg_if.sv
// configuration write channel for the table size register
interface stis_cfg_if;
    import stis_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [SIZE_WIDTH-1:0] table_size;

    modport source (
        output valid, table_size,
        input  ready
    );

    modport sink (
        input  valid, table_size,
        output ready
    );
endinterface

>>> rtl/core/sorted_table_interval_search.sv
// sorted table interval search: table memory, boundary checks and bisection sequencer
//
// channels: req carries one transaction per table write (action = write) or
// key search (action = search); rsp returns one transaction per search and
// none per write; cfg writes the table size, clamped to 2 .. TABLE_DEPTH.
// cfg is always ready; it must be written only while no search is in flight, which the
// block itself does not enforce. a write leaves the sequencer in idle, so req stays ready.
// a search runs from accept to rsp valid in these steps: the first entry is read
// in the accept cycle, S_FIRST compares it and reads the last entry, S_LAST
// compares the last entry, S_PROBE takes the bisection steps and S_DONE loads
// the rsp register, waiting there while an older result is still held.
// each compare works on a read of the table memory, whose read data is registered;
// req is ready only in idle, so one search runs at a time.
// a result waiting in the rsp register does not block req: the next item
// is taken while rsp stalls, and only a later search result waits for it.
// reset empties the rsp register, returns the sequencer to idle and sets the
// table size to 256 (or TABLE_DEPTH if smaller); table contents are not
// cleared and an entry must be written before a search reads it.
module sorted_table_interval_search #(
    parameter int TABLE_DEPTH = stis_pkg::DEFAULT_TABLE_DEPTH,
    parameter int VALUE_WIDTH = stis_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    stis_req_if.sink   req,
    stis_rsp_if.source rsp,
    stis_cfg_if.sink   cfg
);
    import stis_pkg::*;

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CMP_W = (VALUE_WIDTH > KEY_WIDTH) ? VALUE_WIDTH : KEY_WIDTH;
    localparam int SIZE_RST_INT = (SIZE_RESET > TABLE_DEPTH) ? TABLE_DEPTH : SIZE_RESET;
    localparam logic [SIZE_WIDTH-1:0] SIZE_RST = SIZE_WIDTH'(SIZE_RST_INT);
    localparam logic [SIZE_WIDTH-1:0] SIZE_MAX =
        (TABLE_DEPTH > (2 ** SIZE_WIDTH) - 1) ? {SIZE_WIDTH{1'b1}} : SIZE_WIDTH'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_PROBE,
        S_DONE
    } state_t;

    state_t                      state_reg, state_next;
    logic [SIZE_WIDTH-1:0]       size_reg, size_next;
    logic signed [KEY_WIDTH-1:0] key_reg, key_next;
    logic [SIZE_WIDTH-1:0]       lo_reg, lo_next;
    logic [SIZE_WIDTH-1:0]       hi_reg, hi_next;
    logic [SIZE_WIDTH-1:0]       mid_reg, mid_next;
    logic [SIZE_WIDTH-1:0]       result_reg, result_next;
    logic                        first_eq_reg, first_eq_next;
    logic                        oor_reg, oor_next;
    logic                        out_valid_reg, out_valid_next;
    logic [INDEX_WIDTH-1:0]      out_index_reg, out_index_next;
    logic                        out_oor_reg, out_oor_next;

    logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic [SIZE_WIDTH-1:0]  rd_idx;
    logic [AW+SIZE_WIDTH-1:0]  rd_wide;
    logic [AW+INDEX_WIDTH-1:0] wr_wide;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          wr_addr;
    logic                   mem_we;

    logic                    req_fire;
    logic signed [CMP_W-1:0] key_x;
    logic signed [CMP_W-1:0] data_x;
    logic                    eq;
    logic                    lt;
    logic [SIZE_WIDTH-1:0]   nlo;
    logic [SIZE_WIDTH-1:0]   nhi;
    logic [SIZE_WIDTH:0]     mid_sum;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid        = out_valid_reg;
    assign rsp.found_index  = out_index_reg;
    assign rsp.out_of_range = out_oor_reg;

    assign key_x  = CMP_W'(key_reg);
    assign data_x = CMP_W'($signed(rd_data_reg));
    assign eq     = (data_x == key_x);
    assign lt     = (data_x < key_x);

    // a write lands at the edge before the next accept, so a following search reads it
    assign mem_we  = req_fire && (req.action == ACT_WRITE)
                     && (32'(req.entry_index) < 32'(TABLE_DEPTH));
    assign wr_wide = {{AW{1'b0}}, req.entry_index};
    assign wr_addr = wr_wide[AW-1:0];
    assign rd_wide = {{AW{1'b0}}, rd_idx};
    assign rd_addr = rd_wide[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= req.entry_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // candidate bounds after one bisection compare
    assign nlo     = lt ? mid_reg : lo_reg;
    assign nhi     = lt ? hi_reg : mid_reg;

    always_comb
    begin
        state_next     = state_reg;
        size_next      = size_reg;
        key_next       = key_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        result_next    = result_reg;
        first_eq_next  = first_eq_reg;
        oor_next       = oor_reg;
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_oor_next   = out_oor_reg;
        rd_idx         = '0;
        mid_sum        = '0;

        if (cfg.valid && cfg.ready)
        begin
            if (cfg.table_size < SIZE_MIN)
            begin
                size_next = SIZE_MIN;
            end
            else if (cfg.table_size > SIZE_MAX)
            begin
                size_next = SIZE_MAX;
            end
            else
            begin
                size_next = cfg.table_size;
            end
        end

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                rd_idx = '0;
                if (req_fire && (req.action == ACT_SEARCH))
                begin
                    key_next   = req.search_key;
                    lo_next    = '0;
                    hi_next    = size_reg - SIZE_WIDTH'(1);
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                rd_idx        = hi_reg;
                first_eq_next = eq;
                oor_next      = !lt && !eq;
                state_next    = S_LAST;
            end
            S_LAST:
            begin
                oor_next = oor_reg || lt;
                mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
                if (first_eq_reg)
                begin
                    result_next = lo_reg;
                    state_next  = S_DONE;
                end
                else if (eq)
                begin
                    result_next = hi_reg;
                    state_next  = S_DONE;
                end
                else if ((hi_reg - lo_reg) > SIZE_WIDTH'(1))
                begin
                    mid_next   = mid_sum[SIZE_WIDTH:1];
                    rd_idx     = mid_sum[SIZE_WIDTH:1];
                    state_next = S_PROBE;
                end
                else
                begin
                    result_next = lo_reg;
                    state_next  = S_DONE;
                end
            end
            S_PROBE:
            begin
                mid_sum = {1'b0, nlo} + {1'b0, nhi};
                if (eq)
                begin
                    result_next = mid_reg;
                    state_next  = S_DONE;
                end
                else
                begin
                    lo_next = nlo;
                    hi_next = nhi;
                    if ((nhi - nlo) > SIZE_WIDTH'(1))
                    begin
                        mid_next = mid_sum[SIZE_WIDTH:1];
                        rd_idx   = mid_sum[SIZE_WIDTH:1];
                    end
                    else
                    begin
                        result_next = nlo;
                        state_next  = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                // waits here only while an older result is still held in rsp
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = result_reg[INDEX_WIDTH-1:0];
                    out_oor_next   = oor_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= SIZE_RST;
            key_reg       <= '0;
            lo_reg        <= '0;
            hi_reg        <= SIZE_WIDTH'(1);
            mid_reg       <= '0;
            result_reg    <= '0;
            first_eq_reg  <= 1'b0;
            oor_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_oor_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            key_reg       <= key_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            mid_reg       <= mid_next;
            result_reg    <= result_next;
            first_eq_reg  <= first_eq_next;
            oor_reg       <= oor_next;
            out_valid_reg <= out_valid_next;
            out_index_reg <= out_index_next;
            out_oor_reg   <= out_oor_next;
        end
    end

`ifndef ASSERT_OFF
    a_size_floor: assert property (@(posedge clk) disable iff (!rst_n)
        size_reg >= SIZE_MIN)
        else $error("table size below minimum");

    a_bracket_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (lo_reg < hi_reg))
        else $error("bisection bounds crossed");

    a_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> ((mid_reg > lo_reg) && (mid_reg < hi_reg)))
        else $error("probe index outside open interval");

    a_search_start: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.action == ACT_SEARCH)) |=> (state_reg == S_FIRST))
        else $error("accepted search did not start");
`endif

endmodule

>>> tb/sorted_table_interval_search_tb.sv
`timescale 1ns / 100ps
// testbench for the sorted table interval search block: directed table, then random phases
module sorted_table_interval_search_tb;
    import stis_pkg::*;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0] index;
        logic                   out_of_range;
    } lookup_t;

    typedef struct {
        logic                   action;
        logic [INDEX_WIDTH-1:0] entry_index;
        logic signed [31:0]     entry_value;
        logic signed [31:0]     search_key;
        bit                     has_result;
        lookup_t                known_result;
    } stim_row_t;

    localparam int DEPTH = DEFAULT_TABLE_DEPTH;
    localparam logic signed [31:0] KEY_LOW  = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_HIGH = 32'sh7FFF_FFFF;
    localparam longint VAL_MIN = -(64'sd1 <<< 31);
    localparam longint VAL_MAX = (64'sd1 <<< 31) - 1;

    logic clk;
    logic rst_n;

    stis_req_if #(.VALUE_WIDTH(DEFAULT_VALUE_WIDTH)) req_ch ();
    stis_rsp_if rsp_ch ();
    stis_cfg_if cfg_ch ();

    sorted_table_interval_search dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    logic signed [31:0] shadow_table [DEPTH];
    int                 shadow_size;
    lookup_t            pending_lookups [$];
    stim_row_t          directed_rows [$];
    lookup_t            oldest;
    int                 fail_count;
    bit                 quiet;
    bit                 tx_idle_en;
    bit                 rx_idle_en;
    bit                 long_hold;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("sorted_table_interval_search_tb failed");
        $finish;
    end

    // boundary compares first, then bisection over the shadow table
    function automatic lookup_t bisect_lookup(input logic signed [31:0] key);
        lookup_t            r;
        int                 lo;
        int                 hi;
        int                 mid;
        bit                 hit;
        logic signed [31:0] first;
        logic signed [31:0] last;
        logic signed [31:0] probe;
        lo = 0;
        hi = shadow_size - 1;
        first = shadow_table[lo];
        last = shadow_table[hi];
        r.out_of_range = (key < first) || (key > last);
        if (first == key)
        begin
            r.index = 8'(lo);
        end
        else if (last == key)
        begin
            r.index = 8'(hi);
        end
        else
        begin
            hit = 1'b0;
            while (!hit && (hi - lo > 1))
            begin
                mid = (lo + hi) / 2;
                probe = shadow_table[mid];
                if (probe == key)
                begin
                    r.index = 8'(mid);
                    hit = 1'b1;
                end
                else if (probe < key)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid;
                end
            end
            if (!hit)
            begin
                r.index = 8'(lo);
            end
        end
        return r;
    endfunction

    // uniform value in [lo_v, hi_v]; any value when the bounds are inverted
    function automatic logic signed [31:0] rand_between(input longint lo_v, input longint hi_v);
        if (hi_v < lo_v)
        begin
            return $urandom;
        end
        return 32'(lo_v + ({32'd0, $urandom} % (hi_v - lo_v + 1)));
    endfunction

    function automatic logic signed [31:0] pick_key();
        int kind;
        int i;
        kind = $urandom_range(0, 9);
        if (kind <= 3)
        begin
            return shadow_table[$urandom_range(0, shadow_size - 1)];
        end
        if (kind <= 6)
        begin
            i = $urandom_range(0, shadow_size - 2);
            return rand_between(shadow_table[i], shadow_table[i + 1]);
        end
        if (kind == 7)
        begin
            return rand_between(VAL_MIN, shadow_table[0]);
        end
        if (kind == 8)
        begin
            return rand_between(shadow_table[shadow_size - 1], VAL_MAX);
        end
        return $urandom;
    endfunction

    function automatic void add_row(input logic act, input logic [7:0] idx,
                                    input logic signed [31:0] val,
                                    input logic signed [31:0] key, input bit has_result,
                                    input logic [7:0] res_index, input logic res_oor);
        stim_row_t row;
        row.action = act;
        row.entry_index = idx;
        row.entry_value = val;
        row.search_key = key;
        row.has_result = has_result;
        row.known_result.index = res_index;
        row.known_result.out_of_range = res_oor;
        directed_rows.push_back(row);
    endfunction

    // called at a falling edge, returns at a falling edge after the transaction
    task automatic send_req(input logic act, input logic [7:0] idx,
                            input logic signed [31:0] val, input logic signed [31:0] key,
                            input bit has_result, input lookup_t known_result);
        req_ch.action = act;
        req_ch.entry_index = idx;
        req_ch.entry_value = val;
        req_ch.search_key = key;
        req_ch.valid = 1'b1;
        do @(posedge clk); while (!req_ch.ready);
        if (act == ACT_WRITE)
        begin
            shadow_table[idx] = val;
        end
        else
        begin
            pending_lookups.push_back(has_result ? known_result : bisect_lookup(key));
        end
        @(negedge clk);
        if (tx_idle_en && !quiet && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
    endtask

    task automatic write_size(input logic [SIZE_WIDTH-1:0] v);
        cfg_ch.table_size = v;
        cfg_ch.valid = 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        shadow_size = (v < SIZE_MIN) ? int'(SIZE_MIN) : (v > DEPTH) ? DEPTH : int'(v);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // waits until every pending search result is back, then lets the block settle
    task automatic drain_and_settle();
        req_ch.valid = 1'b0;
        while (pending_lookups.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        @(negedge clk);
    endtask

    // ascending fill; a small span gives runs of equal entries
    task automatic fill_table(input int unsigned span);
        longint level;
        int     i;
        level = VAL_MIN + $urandom_range(0, 4096);
        for (i = 0; i < DEPTH; i++)
        begin
            if (level > VAL_MAX)
            begin
                level = VAL_MAX;
            end
            send_req(ACT_WRITE, 8'(i), 32'(level), $urandom, 1'b0, '0);
            level += $urandom_range(0, span);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_lookups.size() == 0)
            begin
                $error("unexpected search transaction: found_index %0d out_of_range %0d",
                       rsp_ch.found_index, rsp_ch.out_of_range);
                fail_count++;
            end
            else
            begin
                oldest = pending_lookups.pop_front();
                if (rsp_ch.found_index !== oldest.index)
                begin
                    $error("found_index: expected %0d, got %0d",
                           oldest.index, rsp_ch.found_index);
                    fail_count++;
                end
                if (rsp_ch.out_of_range !== oldest.out_of_range)
                begin
                    $error("out_of_range: expected %0d, got %0d",
                           oldest.out_of_range, rsp_ch.out_of_range);
                    fail_count++;
                end
            end
        end
    end

    // result side: random stalls, plus one long hold to back up the request side
    initial
    begin
        int held;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                rsp_ch.ready = 1'b0;
                for (held = 0; held < 400; held++)
                begin
                    @(negedge clk);
                end
                long_hold = 1'b0;
                rsp_ch.ready = 1'b1;
            end
            else if (rx_idle_en && !quiet && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                rsp_ch.ready = 1'b1;
            end
            else
            begin
                rsp_ch.ready = 1'b1;
            end
        end
    end

    initial
    begin
        int                     r;
        int                     phase;
        int                     n;
        int                     i;
        logic [SIZE_WIDTH-1:0]  size_val;
        logic signed [31:0]     val;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.action = ACT_WRITE;
        req_ch.entry_index = '0;
        req_ch.entry_value = '0;
        req_ch.search_key = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.table_size = '0;
        fail_count = 0;
        quiet = 1'b0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        long_hold = 1'b0;
        shadow_size = SIZE_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // two-entry table: size below the minimum clamps up
        write_size(SIZE_WIDTH'(1));
        add_row(ACT_WRITE,  8'h00, KEY_LOW,       32'hFFFF_FFFF, 1'b0, 8'd0, 1'b0);
        add_row(ACT_WRITE,  8'h01, KEY_HIGH,      32'h0000_0000, 1'b0, 8'd0, 1'b0);
        add_row(ACT_SEARCH, 8'hFF, 32'hFFFF_FFFF, KEY_LOW,       1'b1, 8'd0, 1'b0);
        add_row(ACT_SEARCH, 8'h00, 32'h0000_0000, KEY_HIGH,      1'b1, 8'd1, 1'b0);
        add_row(ACT_SEARCH, 8'hAA, 32'h5555_5555, 32'h0000_0000, 1'b1, 8'd0, 1'b0);
        // top index is written but never read at this size
        add_row(ACT_WRITE,  8'hFF, 32'h1234_5678, 32'hFFFF_FFFF, 1'b0, 8'd0, 1'b0);
        add_row(ACT_WRITE,  8'h00, 32'h0100_0000, 32'h5555_5555, 1'b0, 8'd0, 1'b0);
        add_row(ACT_WRITE,  8'h01, 32'h0300_0000, 32'hAAAA_AAAA, 1'b0, 8'd0, 1'b0);
        add_row(ACT_SEARCH, 8'h55, 32'hAAAA_AAAA, 32'h0100_0000, 1'b1, 8'd0, 1'b0);
        add_row(ACT_SEARCH, 8'h00, 32'h0000_0000, 32'h0300_0000, 1'b1, 8'd1, 1'b0);
        add_row(ACT_SEARCH, 8'h00, 32'h0000_0000, 32'h0200_0000, 1'b1, 8'd0, 1'b0);
        // keys outside the table
        add_row(ACT_SEARCH, 8'h00, 32'h0000_0000, 32'h00FF_FFFF, 1'b1, 8'd0, 1'b1);
        add_row(ACT_SEARCH, 8'h00, 32'h0000_0000, 32'h0300_0001, 1'b1, 8'd0, 1'b1);
        add_row(ACT_SEARCH, 8'h00, 32'h0000_0000, KEY_LOW,       1'b1, 8'd0, 1'b1);
        add_row(ACT_SEARCH, 8'h00, 32'h0000_0000, KEY_HIGH,      1'b1, 8'd0, 1'b1);
        // descending pair, then equal pair
        add_row(ACT_WRITE,  8'h00, 32'h0500_0000, 32'h0000_0000, 1'b0, 8'd0, 1'b0);
        add_row(ACT_WRITE,  8'h01, 32'h0200_0000, 32'h0000_0000, 1'b0, 8'd0, 1'b0);
        add_row(ACT_SEARCH, 8'h00, 32'h0000_0000, 32'h0300_0000, 1'b0, 8'd0, 1'b0);
        add_row(ACT_SEARCH, 8'h00, 32'h0000_0000, 32'h0500_0000, 1'b0, 8'd0, 1'b0);
        add_row(ACT_WRITE,  8'h01, 32'h0500_0000, 32'h0000_0000, 1'b0, 8'd0, 1'b0);
        add_row(ACT_SEARCH, 8'h00, 32'h0000_0000, 32'h0500_0000, 1'b1, 8'd0, 1'b0);
        for (r = 0; r < directed_rows.size(); r++)
        begin
            send_req(directed_rows[r].action, directed_rows[r].entry_index,
                     directed_rows[r].entry_value, directed_rows[r].search_key,
                     directed_rows[r].has_result, directed_rows[r].known_result);
        end

        for (phase = 0; phase < 10; phase++)
        begin
            drain_and_settle();
            case (phase)
                0: size_val = SIZE_WIDTH'(511);
                1: size_val = SIZE_WIDTH'(256);
                2: size_val = SIZE_WIDTH'(0);
                3: size_val = SIZE_WIDTH'(3);
                4: size_val = SIZE_WIDTH'(257);
                5: size_val = SIZE_WIDTH'(129);
                6: size_val = SIZE_WIDTH'($urandom_range(2, 256));
                7: size_val = SIZE_WIDTH'(2);
                8: size_val = SIZE_WIDTH'(255);
                default: size_val = SIZE_WIDTH'($urandom_range(0, 511));
            endcase
            write_size(size_val);
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            quiet = (phase == 9);
            if (phase == 0 || phase == 4 || phase == 7)
            begin
                fill_table(phase == 0 ? (1 << 25) : (phase == 4 ? 3 : (1 << 20)));
            end
            if (phase == 1)
            begin
                long_hold = 1'b1;
            end
            for (n = 0; n < 40; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    i = $urandom_range(0, DEPTH - 1);
                    // mostly order-preserving rewrites, some that break the order
                    if ($urandom_range(0, 9) < 7)
                    begin
                        val = rand_between(i == 0 ? VAL_MIN : longint'(shadow_table[i - 1]),
                                           i == DEPTH - 1 ? VAL_MAX
                                                          : longint'(shadow_table[i + 1]));
                    end
                    else
                    begin
                        val = $urandom;
                    end
                    send_req(ACT_WRITE, 8'(i), val, $urandom, 1'b0, '0);
                end
                else
                begin
                    send_req(ACT_SEARCH, 8'($urandom), $urandom, pick_key(), 1'b0, '0);
                end
            end
        end

        drain_and_settle();
        if (fail_count == 0)
        begin
            $display("sorted_table_interval_search_tb passed");
        end
        else
        begin
            $display("sorted_table_interval_search_tb failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/stis_pkg.sv
rtl/core/stis_req_if.sv
rtl/core/stis_rsp_if.sv
rtl/core/stis_cfg_if.sv
rtl/core/sorted_table_interval_search.sv
tb/sorted_table_interval_search_tb.sv
